FILE: src/zero_run_visibility_decoder_macros.svh
// Assertion macros for the zero-run visibility decoder.
`ifndef ZERO_RUN_VISIBILITY_DECODER_MACROS_SVH
`define ZERO_RUN_VISIBILITY_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ZRVD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ZRVD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/zrvd_pkg.sv
// Shared types, constants and helpers for the zero-run visibility decoder.
package zrvd_pkg;

    localparam int DEF_MAX_ROW_BYTES = 8192;
    localparam int ROW_REG_W         = 14;
    localparam int BYTE_W            = 8;
    localparam int WORD_BYTES        = 8;
    localparam int WORD_W            = BYTE_W * WORD_BYTES;
    localparam int FILL_W            = 3;
    localparam int COUNT_W           = 4;
    localparam int ADDR_W            = 3;
    localparam int APB_DATA_W        = 32;
    localparam int TDATA_OUT_W       = 72;

    localparam logic [ROW_REG_W-1:0] ROW_RESET = ROW_REG_W'(8192);

    // register index, taken from paddr[2]
    localparam logic REG_ROW_BYTES = 1'b0;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    // one byte handed to the packer
    typedef struct packed
    {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              ovr;
    } place_req_t;

    // width of row length and byte counter
    function automatic int row_w(input int max_bytes);
        int cw;
        cw = $clog2(max_bytes + 1);
        return (cw > ROW_REG_W) ? cw : ROW_REG_W;
    endfunction

endpackage

FILE: src/zrvd_packer.sv
// Byte packer: places one byte per step into a 64-bit word, holds the output register.
module zrvd_packer #(
    parameter int MAX_ROW_BYTES = zrvd_pkg::DEF_MAX_ROW_BYTES
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  zrvd_pkg::place_req_t                          req,
    input  logic [zrvd_pkg::row_w(MAX_ROW_BYTES)-1:0]     row_eff,
    output logic [zrvd_pkg::row_w(MAX_ROW_BYTES)-1:0]     bytes_written,
    output logic                                          slot_free,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [zrvd_pkg::WORD_W-1:0]                   out_word,
    output logic [zrvd_pkg::COUNT_W-1:0]                  out_count,
    output logic                                          out_last,
    output logic                                          out_ovr
);
    import zrvd_pkg::*;

    localparam int RW = row_w(MAX_ROW_BYTES);

    logic [WORD_W-1:0]  buf_reg, buf_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [RW-1:0]      bw_reg, bw_next;
    logic               valid_reg, valid_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               last_reg, last_next;
    logic               ovr_reg, ovr_next;

    logic [WORD_W-1:0]  word_ins;
    logic [COUNT_W-1:0] fill_inc;
    logic [RW:0]        bw_inc;
    logic               row_end;

    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            word_ins[i*BYTE_W +: BYTE_W] = (FILL_W'(i) == fill_reg) ? req.data
                                                                  : buf_reg[i*BYTE_W +: BYTE_W];
        end
        fill_inc = {1'b0, fill_reg} + COUNT_W'(1);
        bw_inc   = {1'b0, bw_reg} + (RW+1)'(1);
        row_end  = bw_inc >= {1'b0, row_eff};

        buf_next   = buf_reg;
        fill_next  = fill_reg;
        bw_next    = bw_reg;
        valid_next = valid_reg && !out_ready;
        word_next  = word_reg;
        count_next = count_reg;
        last_next  = last_reg;
        ovr_next   = ovr_reg;

        if (req.valid)
        begin
            if (row_end)
            begin
                valid_next = 1'b1;
                word_next  = word_ins;
                count_next = fill_inc;
                last_next  = 1'b1;
                ovr_next   = req.ovr;
                buf_next   = '0;
                fill_next  = '0;
                bw_next    = '0;
            end
            else if (fill_inc == COUNT_W'(WORD_BYTES))
            begin
                valid_next = 1'b1;
                word_next  = word_ins;
                count_next = fill_inc;
                last_next  = 1'b0;
                ovr_next   = 1'b0;
                buf_next   = '0;
                fill_next  = '0;
                bw_next    = bw_inc[RW-1:0];
            end
            else
            begin
                buf_next  = word_ins;
                fill_next = fill_inc[FILL_W-1:0];
                bw_next   = bw_inc[RW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            fill_reg  <= '0;
            bw_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg   <= buf_next;
            fill_reg  <= fill_next;
            bw_reg    <= bw_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        count_reg <= count_next;
        last_reg  <= last_next;
        ovr_reg   <= ovr_next;
    end

    assign bytes_written = bw_reg;
    assign out_valid     = valid_reg;
    assign out_word      = word_reg;
    assign out_count     = count_reg;
    assign out_last      = last_reg;
    assign out_ovr       = ovr_reg;

endmodule

FILE: src/zrvd_seq.sv
// Sequencer: decodes markers and counts, steps the packer through zero runs.
module zrvd_seq #(
    parameter int MAX_ROW_BYTES = zrvd_pkg::DEF_MAX_ROW_BYTES
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [zrvd_pkg::BYTE_W-1:0]               in_byte,
    input  logic [zrvd_pkg::row_w(MAX_ROW_BYTES)-1:0] row_eff,
    input  logic [zrvd_pkg::row_w(MAX_ROW_BYTES)-1:0] bytes_written,
    input  logic                                      slot_free,
    output zrvd_pkg::place_req_t                      req,
    output logic                                      busy
);
    import zrvd_pkg::*;

    localparam int RW = row_w(MAX_ROW_BYTES);

    seq_state_t        state_reg, state_next;
    logic              await_reg, await_next;
    logic [BYTE_W-1:0] cnt_reg, cnt_next;
    logic              ovr_reg, ovr_next;

    logic [RW-1:0]     remaining;
    logic              clip;
    logic [BYTE_W-1:0] run_len;
    logic              accept;

    always_comb
    begin
        remaining = (bytes_written < row_eff) ? (row_eff - bytes_written) : RW'(1);
        clip      = RW'(in_byte) > remaining;
        run_len   = clip ? remaining[BYTE_W-1:0] : in_byte;
        accept    = in_valid && in_ready;

        state_next = state_reg;
        await_next = await_reg;
        cnt_next   = cnt_reg;
        ovr_next   = ovr_reg;
        in_ready   = 1'b0;
        req        = '{valid: 1'b0, data: '0, ovr: 1'b0};

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = slot_free;
                if (accept)
                begin
                    if (await_reg)
                    begin
                        await_next = 1'b0;
                        if (run_len != '0)
                        begin
                            cnt_next   = run_len;
                            ovr_next   = clip;
                            state_next = ST_RUN;
                        end
                    end
                    else if (in_byte != '0)
                    begin
                        req.valid = 1'b1;
                        req.data  = in_byte;
                    end
                    else
                    begin
                        await_next = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    req.valid = 1'b1;
                    req.ovr   = (cnt_reg == BYTE_W'(1)) && ovr_reg;
                    cnt_next  = cnt_reg - BYTE_W'(1);
                    if (cnt_reg == BYTE_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            await_reg <= 1'b0;
            cnt_reg   <= '0;
            ovr_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            await_reg <= await_next;
            cnt_reg   <= cnt_next;
            ovr_reg   <= ovr_next;
        end
    end

    assign busy = (state_reg == ST_RUN);

endmodule

FILE: src/zero_run_visibility_decoder.sv
// Zero-run visibility decoder top level: config register, sequencer and packer.
// A literal that completes a word shows it on m_* in the cycle after acceptance.
// A count of n zeros places n zero bytes, clipped at the row end, and input waits until
// they are placed (the shared packer places one byte per cycle while its output slot is free).
// Output stalls hold the packer and s_tready low until the output register frees.
// Reset (rst_n, async, active low): empty word, row counter zero, row_bytes 8192.
`include "zero_run_visibility_decoder_macros.svh"
module zero_run_visibility_decoder #(
    parameter int MAX_ROW_BYTES = zrvd_pkg::DEF_MAX_ROW_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input item stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [zrvd_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] in_byte
    // result item stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [zrvd_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [63:0] out_word, [67:64] byte_count
    output logic                                m_tlast,   // row_done
    output logic                                m_tuser,   // [0] overrun
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [zrvd_pkg::ADDR_W-1:0]         paddr,
    input  logic [zrvd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [zrvd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import zrvd_pkg::*;

    localparam int RW = row_w(MAX_ROW_BYTES);

    // ---------------------------------------------------------------
    // Configuration: single row-length register at byte address 0.
    // ---------------------------------------------------------------
    logic [ROW_REG_W-1:0] row_bytes_reg, row_bytes_next;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ROW_BYTES);

    always_comb
    begin
        row_bytes_next = row_bytes_reg;
        if (cfg_wr)
        begin
            row_bytes_next = pwdata[ROW_REG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= ROW_RESET;
        end
        else
        begin
            row_bytes_reg <= row_bytes_next;
        end
    end

    assign prdata = (paddr[2] == REG_ROW_BYTES) ?
                    APB_DATA_W'(row_bytes_reg) : '0;

    // ---------------------------------------------------------------
    // Effective row length: zero reads as one, saturate at the maximum.
    // ---------------------------------------------------------------
    logic [RW-1:0] row_ext;
    logic [RW-1:0] row_eff;

    assign row_ext = RW'(row_bytes_reg);

    always_comb
    begin
        if (row_ext == '0)
        begin
            row_eff = RW'(1);
        end
        else if (row_ext > RW'(MAX_ROW_BYTES))
        begin
            row_eff = RW'(MAX_ROW_BYTES);
        end
        else
        begin
            row_eff = row_ext;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer and shared byte packer.
    // ---------------------------------------------------------------
    place_req_t         req;
    logic [RW-1:0]      bytes_written;
    logic               slot_free;
    logic               busy;
    logic [WORD_W-1:0]  out_word;
    logic [COUNT_W-1:0] byte_count;

    zrvd_seq #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .row_eff       (row_eff),
        .bytes_written (bytes_written),
        .slot_free     (slot_free),
        .req           (req),
        .busy          (busy)
    );

    zrvd_packer #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_packer (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .row_eff       (row_eff),
        .bytes_written (bytes_written),
        .slot_free     (slot_free),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_word      (out_word),
        .out_count     (byte_count),
        .out_last      (m_tlast),
        .out_ovr       (m_tuser)
    );

    assign m_tdata = {(TDATA_OUT_W - WORD_W - COUNT_W)'(0), byte_count, out_word};

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ZRVD_ASSERT_NOW(a_no_input_in_run, clk, rst_n, busy, !s_tready, "input taken during a zero run")
    `ZRVD_ASSERT_NOW(a_count_range, clk, rst_n, m_tvalid, (byte_count != '0) && (byte_count <= COUNT_W'(WORD_BYTES)), "byte count out of range")
    `ZRVD_ASSERT_NOW(a_full_mid_row, clk, rst_n, m_tvalid && !m_tlast, byte_count == COUNT_W'(WORD_BYTES), "partial word before row end")
    `ZRVD_ASSERT_NOW(a_ovr_at_end, clk, rst_n, m_tvalid && m_tuser, m_tlast, "overrun flag off the last word")

endmodule

FILE: tb/sv/zero_run_visibility_decoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the zero-run visibility decoder: row setup, bytes in, words out.
module zero_run_visibility_decoder_test;
    import zrvd_pkg::*;

    // register map: one row-length register, index 1 is unmapped
    localparam int ROW_INDEX   = int'(REG_ROW_BYTES);
    localparam int SPARE_INDEX = 1;
    localparam int REG_STRIDE  = 4;

    // a zero byte opens a run; the byte after it is the run length
    localparam logic [BYTE_W-1:0] ZERO_MARKER = 8'h00;

    // idle cycles before touching the register: covers a short run still being placed
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 28;

    typedef struct {
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               ovr;
    } row_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    zero_run_visibility_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // words still owed by the block, oldest first
    row_word_t expected_words[$];

    // shadow of the decoder: register copy, word being packed, row position
    logic [ROW_REG_W-1:0] row_setting;
    logic [WORD_W-1:0]    acc_word;
    int                   acc_fill;
    bit                   count_pending;
    int                   row_pos;

    // run statistics
    int  mismatches;
    int  items_sent;
    int  words_seen;
    int  rows_seen;
    int  overruns_seen;

    // both sides skip idling while set
    bit  steady;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // zero acts as one, anything past the maximum saturates
    function automatic int row_limit();
        int r;
        r = int'(row_setting);
        if (r == 0)
            r = 1;
        if (r > DEF_MAX_ROW_BYTES)
            r = DEF_MAX_ROW_BYTES;
        return r;
    endfunction

    // put one decoded byte into the word; close the word when full or at row end
    function automatic void place_byte(input logic [BYTE_W-1:0] b, input logic ovr);
        row_word_t w;
        acc_word[acc_fill*BYTE_W +: BYTE_W] = b;
        acc_fill++;
        row_pos++;
        if (row_pos >= row_limit())
        begin
            w.word  = acc_word;
            w.count = COUNT_W'(acc_fill);
            w.last  = 1'b1;
            w.ovr   = ovr;
            expected_words = {expected_words, w};
            acc_word      = '0;
            acc_fill      = 0;
            row_pos       = 0;
            count_pending = 1'b0;
        end
        else if (acc_fill >= WORD_BYTES)
        begin
            w.word  = acc_word;
            w.count = COUNT_W'(WORD_BYTES);
            w.last  = 1'b0;
            w.ovr   = 1'b0;
            expected_words = {expected_words, w};
            acc_word = '0;
            acc_fill = 0;
        end
    endfunction

    // one compressed byte: literal, run marker, or length of a pending run
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        int   remaining;
        int   run;
        logic ovr;
        if (count_pending)
        begin
            // a row already past a shrunken limit still takes exactly one byte of a non-empty run
            remaining     = (row_pos < row_limit()) ? row_limit() - row_pos : 1;
            run           = int'(b);
            ovr           = 1'b0;
            count_pending = 1'b0;
            if (run > remaining)
            begin
                run = remaining;
                ovr = 1'b1;
            end
            for (int i = 0; i < run; i++)
                place_byte(ZERO_MARKER, (i + 1 == run) ? ovr : 1'b0);
        end
        else if (b != ZERO_MARKER)
            place_byte(b, 1'b0);
        else
            count_pending = 1'b1;
    endfunction

    task automatic flag(input string what, input logic [WORD_W-1:0] want,
                        input logic [WORD_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s at %0t: expected %h, got %h", what, $realtime, want, got);
    endtask

    // Result checker: every handshake on the output side is matched against
    // the oldest predicted word. Sampled at the rising edge, where the block's
    // outputs still hold the values of the previous cycle.
    always @(posedge clk)
    begin : result_check
        row_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
                flag("unexpected word", '0, m_tdata[WORD_W-1:0]);
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata[WORD_W-1:0] !== want.word)
                    flag("out_word", want.word, m_tdata[WORD_W-1:0]);
                if (m_tdata[WORD_W +: COUNT_W] !== want.count)
                    flag("byte_count", WORD_W'(want.count), WORD_W'(m_tdata[WORD_W +: COUNT_W]));
                if (m_tlast !== want.last)
                    flag("row_done", WORD_W'(want.last), WORD_W'(m_tlast));
                if (m_tuser !== want.ovr)
                    flag("overrun", WORD_W'(want.ovr), WORD_W'(m_tuser));
                words_seen++;
                if (want.last)
                    rows_seen++;
                if (want.ovr)
                    overruns_seen++;
            end
        end
    end

    // Output side: a random hold-off before taking each word, none while steady is set.
    // m_tready changes only on falling edges.
    initial
    begin : result_sink
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 4);
            repeat (gap)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Input side: one compressed byte, after a random gap. tvalid is left
    // high on return so back-to-back items need no new edge on it.
    task automatic send_item(input logic [BYTE_W-1:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        decode_byte(b);
        items_sent++;
    endtask

    task automatic send_run(input logic [BYTE_W-1:0] len);
        send_item(ZERO_MARKER);
        send_item(len);
    endtask

    // stop the stream and let every owed word come out, then a few spare cycles
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input int index, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(index * REG_STRIDE);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (index == ROW_INDEX)
            row_setting = value[ROW_REG_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_row_reg();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(ROW_INDEX * REG_STRIDE);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[ROW_REG_W-1:0] !== row_setting)
            flag("row_bytes readback", WORD_W'(row_setting), WORD_W'(prdata[ROW_REG_W-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // register writes only ever happen with the block drained
    task automatic set_row(input int index, input logic [APB_DATA_W-1:0] value);
        settle();
        apb_write(index, value);
        check_row_reg();
    endtask

    // Row length at its reset value: literal extremes, empty run, runs that
    // stay inside a word and one that crosses a word boundary.
    task automatic test_literals_and_markers();
        check_row_reg();
        send_item(8'hFF);
        send_item(8'h01);
        send_item(8'h80);
        send_item(8'h7F);
        send_item(8'h55);
        send_item(8'hAA);
        send_run(8'd0);
        send_run(8'd1);
        send_run(8'd9);
        send_item(8'h3C);
    endtask

    // Row length lowered below the bytes already written in the row: the
    // next byte ends the row, a longer run is flagged, a run of one is not.
    task automatic test_shrunken_row();
        set_row(ROW_INDEX, 5);
        send_run(8'd5);
        send_item(8'h11);
        send_item(8'h22);
        send_item(8'h33);
        set_row(ROW_INDEX, 2);
        send_item(8'h44);
        set_row(ROW_INDEX, 9);
        send_item(8'h0F);
        send_item(8'hF0);
        send_item(8'hC3);
        send_item(8'h5A);
        set_row(ROW_INDEX, 3);
        send_run(8'd1);
        send_run(8'd0);
    endtask

    // Degenerate and maximal rows: zero length, a write to the unmapped
    // index, an all-ones write that saturates, and a full-length row filled
    // by runs with the last one clipped at the row end.
    task automatic test_row_extremes();
        set_row(ROW_INDEX, 0);
        send_item(8'h99);
        send_run(8'd0);
        send_run(8'd255);
        send_run(8'd1);
        set_row(SPARE_INDEX, 50);
        send_item(8'h42);
        send_item(8'h24);
        set_row(ROW_INDEX, 32'hFFFF_FFFF);
        steady = 1'b1;
        repeat (32) send_run(8'd255);
        send_run(8'd40);
        steady = 1'b0;
    endtask

    // Random phases over a spread of row lengths. Mostly literals and
    // complete runs; the rest raw bytes, which can open or break a run.
    // Every third phase runs without idling; each phase drains at its start and at most once more.
    task automatic test_random_rows();
        logic [APB_DATA_W-1:0] settings [10];
        int                    n;
        int                    pause_at;
        int                    kind;
        int                    len;
        settings = '{32'd1, 32'd2, 32'd7, 32'd8, 32'd9, 32'd16, 32'd63, 32'd200,
                     32'd8193, 32'hABCD_0009};
        for (int p = 0; p < 10; p++)
        begin
            set_row(ROW_INDEX, settings[p]);
            steady   = (p % 3 == 2);
            pause_at = $urandom_range(5, PHASE_ITEMS - 5);
            n        = 0;
            while (n < PHASE_ITEMS)
            begin
                if (n == pause_at)
                    settle();
                kind = $urandom_range(0, 9);
                if (kind < 5)
                begin
                    send_item(BYTE_W'($urandom_range(1, 255)));
                    n++;
                end
                else if (kind < 9)
                begin
                    case ($urandom_range(0, 3))
                        0: len = $urandom_range(0, 9);
                        1: len = $urandom_range(0, (row_limit() + 2 > 255) ? 255 : row_limit() + 2);
                        2: len = $urandom_range(0, 255);
                        default: len = $urandom_range(0, 16);
                    endcase
                    send_run(BYTE_W'(len));
                    n += 2;
                end
                else
                begin
                    send_item(BYTE_W'($urandom_range(0, 255)));
                    n++;
                end
            end
            steady = 1'b0;
        end
    endtask

    // Main sequence: reset once, directed tests, random phases, then drain.
    initial
    begin : run_tests
        int waited;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        steady        = 1'b0;
        row_setting   = ROW_RESET;
        acc_word      = '0;
        acc_fill      = 0;
        count_pending = 1'b0;
        row_pos       = 0;
        mismatches    = 0;
        items_sent    = 0;
        words_seen    = 0;
        rows_seen     = 0;
        overruns_seen = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_literals_and_markers();
        test_shrunken_row();
        test_row_extremes();
        test_random_rows();

        @(negedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_words.size() != 0)
            $display("%0d predicted words never arrived", expected_words.size());
        $display("Sent %0d compressed items, checked %0d words over %0d rows (%0d clipped).",
                 items_sent, words_seen, rows_seen, overruns_seen);
        $display("Rows from zero length to the saturated maximum, shrunk mid-row, with stalls.");
        if (mismatches == 0 && expected_words.size() == 0)
            $display("zero_run_visibility_decoder_test OK");
        else
            $display("zero_run_visibility_decoder_test NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("zero_run_visibility_decoder_test NOT OK");
        $finish;
    end

endmodule
